// File: rtl/core/chd_pkg.sv
// ----------------------------------------------------------------------------
// Canonical Huffman decoder package
// Shared types, constants and state codes for the decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

	localparam int NUM_SYMBOLS_DEF = 256;
	localparam int MAX_LEN_DEF = 32;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_BUILD = 2'd2,
		FUNC_BIT   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LEN_LONG = 2'd1,
		ST_CODE_MAX = 2'd2,
		ST_NO_BUILD = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_CNT_RD,
		S_CNT_WR,
		S_FIRST,
		S_FILL_RD,
		S_FILL_WR,
		S_BIT_RD,
		S_BIT_CHK,
		S_SYM_RD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] load_symbol;
		logic [5:0] code_length;
		logic       code_bit;
	} in_item_t;

	typedef struct packed {
		logic       symbol_valid;
		logic [7:0] symbol_out;
		logic       stream_done;
		logic [1:0] status;
	} out_item_t;

endpackage

// File: rtl/core/chd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/canonical_huffman_decoder.sv
// From input beat to result beat: a clear walks S_CLR over the length table, a load goes
// straight to S_OUT, and a code bit passes S_BIT_RD, S_BIT_CHK and, on a hit, S_SYM_RD.
// Build makes two walks of the length table RAM, each entry read and then updated, and one
// pass over the per-length registers. Items are handled one at a time; the next item is
// accepted the cycle after the result beat is taken. After reset the length table is cleared
// by a pass over all NUM_SYMBOLS entries while no item is accepted; expected_q resets to zero.
// ----------------------------------------------------------------------------
// Canonical Huffman decoder
// Bit-serial decoder with length table, canonical build and sorted store.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder
	import chd_pkg::*;
#(
	parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      psel,
	input  logic      penable,
	input  logic      pwrite,
	input  logic      paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic      pready
);

	localparam int SW = $clog2(NUM_SYMBOLS);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = SW + 1;

	state_t state_q, state_n;
	logic boot_q;
	logic [31:0] expected_q;
	logic [SW:0] idx_q;
	logic [LW-1:0] len_q;
	logic [CW-1:0] cnt_q  [1:MAX_LEN];
	logic [31:0]   first_q[1:MAX_LEN];
	logic [CW-1:0] off_q  [1:MAX_LEN];
	logic [31:0] code_acc_q;
	logic [CW-1:0] total_q;
	logic [31:0] pcode_q;
	logic [LW-1:0] plen_q;
	logic [31:0] dec_q;
	logic ready_q;
	in_item_t item_q;
	out_item_t res_q;
	out_item_t res_init;

	// length table RAM
	logic lt_we;
	logic [SW-1:0] lt_waddr, lt_raddr;
	logic [5:0] lt_wdata, lt_rdata;
	chd_ram #(.WIDTH(6), .DEPTH(NUM_SYMBOLS)) u_len (
		.clk(clk), .we(lt_we), .waddr(lt_waddr), .wdata(lt_wdata),
		.raddr(lt_raddr), .rdata(lt_rdata)
	);

	// sorted symbol RAM
	logic ss_we;
	logic [SW-1:0] ss_waddr, ss_raddr;
	logic [7:0] ss_wdata, ss_rdata;
	chd_ram #(.WIDTH(8), .DEPTH(NUM_SYMBOLS)) u_sort (
		.clk(clk), .we(ss_we), .waddr(ss_waddr), .wdata(ss_wdata),
		.raddr(ss_raddr), .rdata(ss_rdata)
	);

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? expected_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			expected_q <= pwdata;
		end
	end

	logic [LW-1:0] lt_len;
	logic lt_ok;
	logic [LW:0] plen_inc;
	logic [LW-1:0] plen_nx;
	logic [31:0] pcode_nx, sub_idx;
	logic hit;
	logic take;
	logic [CW-1:0] cnt_prev;
	assign lt_len = lt_rdata[LW-1:0];
	assign lt_ok = (lt_rdata != 6'd0) && ({26'd0, lt_rdata} <= 32'(MAX_LEN));
	assign plen_inc = {1'b0, plen_q} + 1'b1;
	assign plen_nx = (plen_inc > (LW+1)'(MAX_LEN)) ? LW'(MAX_LEN) : plen_inc[LW-1:0];
	assign pcode_nx = {pcode_q[30:0], item_q.code_bit};
	assign sub_idx = pcode_nx - first_q[plen_nx];
	assign hit = (cnt_q[plen_nx] != '0) && (sub_idx < 32'(cnt_q[plen_nx]));
	assign take = ready_q && (dec_q < expected_q);
	assign cnt_prev = (len_q <= LW'(1)) ? '0 : cnt_q[len_q - 1'b1];
	logic [CW-1:0] pos;
	assign pos = off_q[plen_nx] + sub_idx[CW-1:0];

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;

	// first result value for an accepted beat
	always_comb begin
		res_init = '0;
		if (in_data.func == FUNC_LOAD) begin
			res_init.stream_done = (dec_q >= expected_q);
			if ({26'd0, in_data.code_length} > 32'(MAX_LEN))
				res_init.status = ST_LEN_LONG;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (func_t'(in_data.func))
						FUNC_CLEAR: state_n = S_CLR;
						FUNC_LOAD:  state_n = S_OUT;
						FUNC_BUILD: state_n = S_CNT_RD;
						FUNC_BIT:   state_n = S_BIT_RD;
						default:    state_n = S_OUT;
					endcase
				end
			end
			S_CLR: begin
				if (idx_q == (SW+1)'(NUM_SYMBOLS - 1))
					state_n = boot_q ? S_IDLE : S_OUT;
			end
			S_CNT_RD:  state_n = S_CNT_WR;
			S_CNT_WR:  state_n = (idx_q == (SW+1)'(NUM_SYMBOLS)) ? S_FIRST : S_CNT_RD;
			S_FIRST:   state_n = (len_q == LW'(MAX_LEN)) ? S_FILL_RD : S_FIRST;
			S_FILL_RD: state_n = S_FILL_WR;
			S_FILL_WR: state_n = (idx_q == (SW+1)'(NUM_SYMBOLS)) ? S_OUT : S_FILL_RD;
			S_BIT_RD:  state_n = S_BIT_CHK;
			S_BIT_CHK: state_n = (take && hit) ? S_SYM_RD : S_OUT;
			S_SYM_RD:  state_n = S_OUT;
			S_OUT:     state_n = out_ready ? S_IDLE : S_OUT;
			default:   state_n = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		lt_we = 1'b0;
		lt_waddr = idx_q[SW-1:0];
		lt_wdata = '0;
		lt_raddr = idx_q[SW-1:0];
		ss_we = 1'b0;
		ss_waddr = off_q[lt_len][SW-1:0];
		ss_wdata = 8'(idx_q - 1'b1);
		ss_raddr = pos[SW-1:0];
		if (state_q == S_CLR) begin
			lt_we = 1'b1;
		end
		if (state_q == S_IDLE && in_valid && in_data.func == FUNC_LOAD
				&& {26'd0, in_data.code_length} <= 32'(MAX_LEN)
				&& {24'd0, in_data.load_symbol} < 32'(NUM_SYMBOLS)) begin
			lt_we = 1'b1;
			lt_waddr = in_data.load_symbol[SW-1:0];
			lt_wdata = in_data.code_length;
		end
		if (state_q == S_FILL_WR && lt_ok) begin
			ss_we = 1'b1;
		end
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			boot_q <= 1'b1;
			idx_q <= '0;
			len_q <= '0;
			code_acc_q <= '0;
			total_q <= '0;
			pcode_q <= '0;
			plen_q <= '0;
			dec_q <= '0;
			ready_q <= 1'b0;
			item_q <= '0;
			res_q <= '0;
			for (int i = 1; i <= MAX_LEN; i++) begin
				cnt_q[i] <= '0;
				first_q[i] <= '0;
				off_q[i] <= '0;
			end
		end else begin
			state_q <= state_n;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_valid) begin
						item_q <= in_data;
						res_q <= res_init;
						if (in_data.func == FUNC_LOAD) begin
							ready_q <= 1'b0;
						end else if (in_data.func == FUNC_CLEAR) begin
							ready_q <= 1'b0;
							pcode_q <= '0;
							plen_q <= '0;
							dec_q <= '0;
						end else if (in_data.func == FUNC_BUILD) begin
							for (int i = 1; i <= MAX_LEN; i++) cnt_q[i] <= '0;
						end
					end
				end
				S_CLR: begin
					idx_q <= idx_q + 1'b1;
					res_q.stream_done <= (dec_q >= expected_q);
					if (idx_q == (SW+1)'(NUM_SYMBOLS - 1)) boot_q <= 1'b0;
				end
				S_CNT_RD: idx_q <= idx_q + 1'b1;
				S_CNT_WR: begin
					if (lt_ok) cnt_q[lt_len] <= cnt_q[lt_len] + 1'b1;
					len_q <= LW'(1);
					code_acc_q <= '0;
					total_q <= '0;
					if (idx_q == (SW+1)'(NUM_SYMBOLS)) idx_q <= '0;
				end
				S_FIRST: begin
					first_q[len_q] <= (code_acc_q + 32'(cnt_prev)) << 1;
					code_acc_q <= (code_acc_q + 32'(cnt_prev)) << 1;
					off_q[len_q] <= total_q;
					total_q <= total_q + cnt_q[len_q];
					len_q <= len_q + 1'b1;
				end
				S_FILL_RD: idx_q <= idx_q + 1'b1;
				S_FILL_WR: begin
					if (idx_q == (SW+1)'(NUM_SYMBOLS)) begin
						// restore offsets: offset = running fill minus count
						for (int i = 1; i <= MAX_LEN; i++) off_q[i] <= off_q[i] - cnt_q[i]
							+ ((lt_ok && LW'(i) == lt_len) ? CW'(1) : CW'(0));
						pcode_q <= '0;
						plen_q <= '0;
						dec_q <= '0;
						ready_q <= 1'b1;
						res_q.stream_done <= (32'd0 >= expected_q);
					end else if (lt_ok) begin
						off_q[lt_len] <= off_q[lt_len] + 1'b1;
					end
				end
				S_BIT_RD: begin
					res_q.stream_done <= (dec_q >= expected_q);
					if (!ready_q) begin
						res_q.status <= ST_NO_BUILD;
					end
				end
				S_BIT_CHK: begin
					if (take) begin
						if (hit) begin
							dec_q <= dec_q + 1'b1;
							pcode_q <= '0;
							plen_q <= '0;
							res_q.symbol_valid <= 1'b1;
							res_q.stream_done <= (dec_q + 1'b1 >= expected_q);
						end else if (plen_nx >= LW'(MAX_LEN)) begin
							pcode_q <= '0;
							plen_q <= '0;
							res_q.status <= ST_CODE_MAX;
						end else begin
							pcode_q <= pcode_nx;
							plen_q <= plen_nx;
						end
					end
				end
				S_SYM_RD: res_q.symbol_out <= ss_rdata;
				default: ;
			endcase
		end
	end

	// result beat only leaves from the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("result beat outside output state");
	// no item taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input open during result");
	// symbol beats only once codes are built
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res_q.symbol_valid) |-> ready_q) else $error("symbol without build");
	// running length never exceeds the maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		plen_q < LW'(MAX_LEN)) else $error("running code too long");

endmodule
